// File: hdl/ito_pkg.sv
// ----------------------------------------------------------------------------
// ito_pkg: shared types and constants for the integer to ascii formatter
// word layouts, conversion codes, state encoding and the digit character map
// ----------------------------------------------------------------------------
package ito_pkg;

    typedef enum logic [2:0] {
        CMD_SDEC = 3'd0,
        CMD_UDEC = 3'd1,
        CMD_OCT  = 3'd2,
        CMD_HEXL = 3'd3,
        CMD_HEXU = 3'd4,
        CMD_PTR  = 3'd5
    } t_cmd;

    localparam logic [1:0] SEL_DEFAULT  = 2'd0;
    localparam logic [1:0] SEL_LONG     = 2'd1;
    localparam logic [1:0] SEL_LONGLONG = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int unsigned ARG_W   = 64;
    localparam int unsigned SR_W    = 80;
    localparam int unsigned BCD_DIG = 20;
    localparam int unsigned HEX_DIG = 16;
    localparam int unsigned OCT_DIG = 22;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [1:0]       size_sel;
        logic [ARG_W-1:0] arg_value;
    } t_fmt_in;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_fmt_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_PREFIX,
        ST_DIGITS
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0, d};
        end else if (upper) begin
            c = CH_UPA + {4'b0, d} - 8'd10;
        end else begin
            c = CH_LOWA + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf style integer to ascii conversion
// decimal via bit-serial double dabble, octal and hex by digit shifting;
// at most one character word per cycle, most significant digit first
// ----------------------------------------------------------------------------
// sequence: decimal first runs double dabble over all 64 argument bits, then the
//   prefix characters and the digit slots (20 decimal, 22 octal, 16 hex) follow in
//   order; leading zero slots are skipped without a word
// handshake: one number at a time, taken only while idle; busy is low again as the
//   last character word is shown, and the receiver cannot stall
// reset: synchronous active low; back to idle, r_long_wide reads 1
module integer_to_ascii_formatter
    import ito_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_fmt_in  i_cmd,
    output logic     o_res_valid,
    output t_fmt_out o_res,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    t_state          r_state, n_state;
    logic            r_long_wide;
    logic [ARG_W-1:0] r_bin;
    logic [SR_W-1:0] r_sr;
    logic [5:0]      r_cnt;
    logic [4:0]      r_left;
    logic            r_seen;
    logic            r_b3;
    logic            r_upper;
    logic            r_ptr;
    logic [1:0]      r_npre;
    logic            r_res_valid, n_res_valid;
    t_fmt_out        r_res, n_res;

    logic            accept;
    logic            wide;
    logic            cmd_ok;
    logic [ARG_W-1:0] v_s, v_u, mag;
    logic            neg;
    logic [3:0]      digit;
    logic            emit;
    logic [SR_W-1:0] bcd_adj;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign wide   = (i_cmd.size_sel == SEL_LONGLONG) ||
                    ((i_cmd.size_sel == SEL_LONG) && r_long_wide);
    assign cmd_ok = (i_cmd.cmd <= CMD_PTR);
    assign v_s    = wide ? i_cmd.arg_value
                         : {{32{i_cmd.arg_value[31]}}, i_cmd.arg_value[31:0]};
    assign neg    = v_s[ARG_W-1];
    assign mag    = neg ? (~v_s + 64'd1) : v_s;
    assign v_u    = wide ? i_cmd.arg_value : {32'b0, i_cmd.arg_value[31:0]};

    assign digit = r_b3 ? {1'b0, r_sr[SR_W-1 -: 3]} : r_sr[SR_W-1 -: 4];
    // leading zeros are dropped, but the last slot always prints
    assign emit  = r_seen || (digit != 4'd0) || (r_left == 5'd1);

    // add three to every bcd digit of five or more before the shift
    always_comb begin
        bcd_adj = r_sr;
        for (int i = 0; i < BCD_DIG; i++) begin
            if (r_sr[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_sr[4*i +: 4] + 4'd3;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && cmd_ok) begin
                    if (i_cmd.cmd == CMD_SDEC || i_cmd.cmd == CMD_UDEC) begin
                        n_state = ST_DABBLE;
                    end else if (i_cmd.cmd == CMD_PTR) begin
                        n_state = ST_PREFIX;
                    end else begin
                        n_state = ST_DIGITS;
                    end
                end
            end
            ST_DABBLE: begin
                if (r_cnt == 6'd0) begin
                    n_state = (r_npre != 2'd0) ? ST_PREFIX : ST_DIGITS;
                end
            end
            ST_PREFIX: begin
                if (r_npre == 2'd1) begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (r_left == 5'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result word
    always_comb begin
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (r_state)
            ST_PREFIX: begin
                n_res_valid = 1'b1;
                n_res.last  = 1'b0;
                if (!r_ptr) begin
                    n_res.ch = CH_MINUS;
                end else begin
                    n_res.ch = (r_npre == 2'd2) ? CH_ZERO : CH_X;
                end
            end
            ST_DIGITS: begin
                n_res_valid = emit;
                n_res.ch    = digit_char(digit, r_upper);
                n_res.last  = (r_left == 5'd1);
            end
            ST_IDLE, ST_DABBLE: begin
                n_res_valid = 1'b0;
            end
            default: n_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_long_wide <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_long_wide <= i_cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_seen  <= 1'b0;
                    r_cnt   <= 6'd63;
                    r_upper <= (i_cmd.cmd == CMD_HEXU);
                    r_ptr   <= (i_cmd.cmd == CMD_PTR);
                    r_b3    <= (i_cmd.cmd == CMD_OCT);
                    r_npre  <= 2'd0;
                    case (i_cmd.cmd)
                        CMD_SDEC: begin
                            r_bin  <= mag;
                            r_sr   <= '0;
                            r_left <= 5'(BCD_DIG);
                            r_npre <= neg ? 2'd1 : 2'd0;
                        end
                        CMD_UDEC: begin
                            r_bin  <= v_u;
                            r_sr   <= '0;
                            r_left <= 5'(BCD_DIG);
                        end
                        CMD_OCT: begin
                            r_sr   <= {2'b00, v_u, 14'b0};
                            r_left <= 5'(OCT_DIG);
                        end
                        CMD_PTR: begin
                            r_sr   <= {i_cmd.arg_value, 16'b0};
                            r_left <= 5'(HEX_DIG);
                            r_npre <= 2'd2;
                        end
                        default: begin
                            r_sr   <= {v_u, 16'b0};
                            r_left <= 5'(HEX_DIG);
                        end
                    endcase
                end
            end
            ST_DABBLE: begin
                r_sr  <= {bcd_adj[SR_W-2:0], r_bin[ARG_W-1]};
                r_bin <= {r_bin[ARG_W-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_PREFIX: begin
                r_npre <= r_npre - 2'd1;
            end
            ST_DIGITS: begin
                r_sr   <= r_b3 ? {r_sr[SR_W-4:0], 3'b0} : {r_sr[SR_W-5:0], 4'b0};
                r_left <= r_left - 5'd1;
                if (emit) begin
                    r_seen <= 1'b1;
                end
            end
            default: begin
                r_seen <= r_seen;
            end
        endcase
    end

endmodule

// File: hdl/ito_checker.sv
// ----------------------------------------------------------------------------
// ito_checker: port level checks for the integer to ascii formatter
// watches the command, result and configuration handshakes over time
// ----------------------------------------------------------------------------
module ito_checker
    import ito_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input t_fmt_in  i_cmd,
    input logic     o_res_valid,
    input t_fmt_out o_res,
    input logic     i_cfg_valid,
    input logic     o_cfg_ready
);

    // a word only follows a busy cycle
    a_word_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(o_busy))
        else $error("result word without a busy cycle before it");

    // configuration is taken only while idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_busy)
        else $error("configuration ready while busy");

    // a valid conversion started while idle makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_cmd.cmd <= CMD_PTR)) |=> o_busy)
        else $error("accepted conversion did not raise busy");

    // nothing follows the last character until a new number starts
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("word right after the last character");

    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.ch != 8'h00))
        else $error("null character word");

endmodule

bind integer_to_ascii_formatter ito_checker u_ito_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_cmd       (i_cmd),
    .o_res_valid (o_res_valid),
    .o_res       (o_res),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// File: verif/integer_to_ascii_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb: self-checking bench for the integer formatter
// drives conversion commands through the start/busy port, predicts every
// character word in the bench and compares each strobed word in order;
// covers all conversions, length selectors, the long width setting, the
// sign, zero and pointer cases, unused codes and random traffic with gaps
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
    import ito_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned SETTLE_CYC   = 100;
    localparam int unsigned PRINT_CAP    = 40;
    localparam logic [2:0]  CMD_UNUSED6  = 3'd6;
    localparam logic [2:0]  CMD_UNUSED7  = 3'd7;
    localparam logic [1:0]  SEL_RESERVED = 2'd3;
    localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
    localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_start     = 1'b0;
    t_fmt_in  i_cmd       = '0;
    logic     i_cfg_valid = 1'b0;
    logic     i_cfg_data  = 1'b0;
    logic     o_busy;
    logic     o_res_valid;
    t_fmt_out o_res;
    logic     o_cfg_ready;

    t_fmt_out    pending_chars[$];
    logic        long_wide    = 1'b1;
    logic        gaps_on      = 1'b1;
    int unsigned quiet_left   = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    integer_to_ascii_formatter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_to_ascii_formatter_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    // expected characters of one conversion, appended to pending_chars
    function automatic void predict_chars(input logic [2:0] cmd, input logic [1:0] sel,
                                          input logic [63:0] arg);
        logic       wide;
        logic       upper;
        logic       neg;
        logic       ptr;
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0] digs [0:21];
        int         nd;
        int         idx;
        t_fmt_out   w;
        wide  = (sel == SEL_LONGLONG) || (sel == SEL_LONG && long_wide);
        mag   = arg;
        base  = 64'd10;
        upper = 1'b0;
        neg   = 1'b0;
        ptr   = 1'b0;
        case (cmd)
            CMD_SDEC: begin
                if (!wide) mag = {{32{arg[31]}}, arg[31:0]};
                if (mag[63]) begin
                    neg = 1'b1;
                    mag = ~mag + 64'd1;
                end
            end
            CMD_UDEC, CMD_OCT, CMD_HEXL, CMD_HEXU: begin
                if (!wide) mag = {32'd0, arg[31:0]};
                if (cmd == CMD_OCT) base = 64'd8;
                else if (cmd == CMD_HEXL || cmd == CMD_HEXU) base = 64'd16;
                upper = (cmd == CMD_HEXU);
            end
            CMD_PTR: begin
                ptr  = 1'b1;
                base = 64'd16;
            end
            default: return;
        endcase
        nd = 0;
        do begin
            idx = int'(mag % base);
            digs[nd] = upper ? UPPER_DIGITS[8*(15-idx) +: 8] : LOWER_DIGITS[8*(15-idx) +: 8];
            nd++;
            mag = mag / base;
        end while (mag != 64'd0);
        w.last = 1'b0;
        if (neg) begin
            w.ch = CH_MINUS;
            pending_chars.push_back(w);
        end
        if (ptr) begin
            w.ch = CH_ZERO;
            pending_chars.push_back(w);
            w.ch = CH_X;
            pending_chars.push_back(w);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            w.ch   = digs[i];
            w.last = (i == 0);
            pending_chars.push_back(w);
        end
    endfunction

    // compare every strobed word with the oldest prediction
    always @(posedge i_clk) begin
        t_fmt_out want;
        if (i_rst_n && o_res_valid) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word ch=%h last=%b",
                                          o_res.ch, o_res.last));
            end else begin
                want = pending_chars.pop_front();
                if (o_res.ch !== want.ch)
                    report_mismatch($sformatf("ch got %h expected %h", o_res.ch, want.ch));
                if (o_res.last !== want.last)
                    report_mismatch($sformatf("last got %b expected %b (ch %h)",
                                              o_res.last, want.last, want.ch));
            end
        end
    end

    // present one command and hold it until the block takes it
    task automatic send_item(input logic [2:0] cmd, input logic [1:0] sel,
                             input logic [63:0] arg);
        i_start         <= 1'b1;
        i_cmd.cmd       <= cmd;
        i_cmd.size_sel  <= sel;
        i_cmd.arg_value <= arg;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_chars(cmd, sel, arg);
        if (quiet_left > 0) begin
            quiet_left--;
        end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end else if (gaps_on && $urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(5, 20);
        end
    endtask

    task automatic drain_outputs();
        i_start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        // extra quiet time before a configuration write or the end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_long_width(input logic wide);
        drain_outputs();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= wide;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        long_wide    = wide;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 20));
            2: v = {$urandom, $urandom};
            3: begin
                case ($urandom_range(0, 5))
                    0: v = 64'h0000_0000_7fff_ffff;
                    1: v = 64'h0000_0000_8000_0000;
                    2: v = 64'h0000_0000_ffff_ffff;
                    3: v = 64'h7fff_ffff_ffff_ffff;
                    4: v = 64'h8000_0000_0000_0000;
                    default: v = 64'hffff_ffff_ffff_ffff;
                endcase
                v = v + 64'($urandom_range(0, 4)) - 64'd2;
            end
            4: begin
                v = 64'd1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1)) v = v - 64'd1;
            end
            default: v = 64'd0 - 64'($urandom_range(1, 1000));
        endcase
        // upper half noise for the 32-bit widths
        if ($urandom_range(0, 3) == 0) v[63:32] = $urandom;
        return v;
    endfunction

    task automatic test_directed();
        send_item(CMD_SDEC, SEL_DEFAULT,  64'd0);
        send_item(CMD_SDEC, SEL_DEFAULT,  64'hffff_ffff_ffff_ffff);
        send_item(CMD_SDEC, SEL_DEFAULT,  64'h0000_0000_8000_0000);
        send_item(CMD_SDEC, SEL_DEFAULT,  64'habcd_0000_7fff_ffff);
        send_item(CMD_SDEC, SEL_LONGLONG, 64'h8000_0000_0000_0000);
        send_item(CMD_SDEC, SEL_LONGLONG, 64'h7fff_ffff_ffff_ffff);
        send_item(CMD_SDEC, SEL_LONG,     64'h0000_0000_8000_0000);
        send_item(CMD_UDEC, SEL_LONGLONG, 64'hffff_ffff_ffff_ffff);
        send_item(CMD_UDEC, SEL_DEFAULT,  64'hffff_ffff_ffff_ffff);
        send_item(CMD_UDEC, SEL_DEFAULT,  64'd0);
        send_item(CMD_OCT,  SEL_LONGLONG, 64'hffff_ffff_ffff_ffff);
        send_item(CMD_OCT,  SEL_DEFAULT,  64'd1);
        send_item(CMD_OCT,  SEL_LONGLONG, 64'd0);
        send_item(CMD_HEXL, SEL_LONGLONG, 64'hdead_beef_cafe_f00d);
        send_item(CMD_HEXU, SEL_LONGLONG, 64'hdead_beef_cafe_f00d);
        send_item(CMD_HEXU, SEL_RESERVED, 64'hdead_beef_cafe_f00d);
        send_item(CMD_HEXL, SEL_LONG,     64'h0000_0001_0000_0000);
        send_item(CMD_PTR,  SEL_DEFAULT,  64'hffff_ffff_ffff_ffff);
        send_item(CMD_PTR,  SEL_LONGLONG, 64'd0);
        send_item(CMD_PTR,  SEL_RESERVED, 64'h0000_0001_2345_6789);
        send_item(CMD_UNUSED6, SEL_DEFAULT, 64'h1234);
        send_item(CMD_UNUSED7, SEL_LONGLONG, 64'hffff_ffff_ffff_ffff);
        send_item(CMD_SDEC, SEL_RESERVED, 64'hffff_ffff_8000_0000);
    endtask

    // long selector follows the width setting, long long does not
    task automatic test_long_width();
        write_long_width(1'b0);
        send_item(CMD_SDEC, SEL_LONG,     64'h0000_0000_8000_0000);
        send_item(CMD_UDEC, SEL_LONG,     64'hffff_ffff_ffff_ffff);
        send_item(CMD_OCT,  SEL_LONG,     64'hffff_ffff_ffff_ffff);
        send_item(CMD_HEXL, SEL_LONG,     64'h0000_0001_0000_0000);
        send_item(CMD_PTR,  SEL_LONG,     64'hffff_ffff_0000_0000);
        send_item(CMD_SDEC, SEL_LONGLONG, 64'h8000_0000_0000_0000);
        write_long_width(1'b1);
        send_item(CMD_SDEC, SEL_LONG,     64'h8000_0000_0000_0000);
        send_item(CMD_HEXU, SEL_LONG,     64'h0000_0001_0000_0000);
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned sent;
        logic [2:0]  cmd;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 15) == 0) begin
                cmd = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
            end else begin
                cmd = 3'($urandom_range(0, 5));
            end
            send_item(cmd, 2'($urandom_range(0, 3)), pick_value());
            sent++;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_width();
        test_random(110);
        write_long_width(1'b0);
        test_random(110);
        write_long_width(1'b1);
        test_random(100);
        gaps_on    = 1'b0;
        quiet_left = 0;
        test_random(59);
        drain_outputs();
        if (error_count == 0) begin
            $display("integer_to_ascii_formatter_tb: PASS");
        end else begin
            $display("integer_to_ascii_formatter_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: integer_to_ascii_formatter.f
hdl/ito_pkg.sv
hdl/integer_to_ascii_formatter.sv
hdl/ito_checker.sv
verif/integer_to_ascii_formatter_tb.sv
